### src/per_host_window_throttle_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the per-host window throttle
// Concurrent checks clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef PER_HOST_WINDOW_THROTTLE_DEFINES_SVH
`define PER_HOST_WINDOW_THROTTLE_DEFINES_SVH
`ifndef SYNTHESIS
`define PHWT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define PHWT_NEVER(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define PHWT_ASSERT(lbl, prop, msg)
`define PHWT_NEVER(lbl, expr, msg)
`endif
`endif

### src/phwt_pkg.sv
// ----------------------------------------------------------------------------
// phwt_pkg
// Shared types, register indexes, verdict codes and reset values.
// ----------------------------------------------------------------------------
package phwt_pkg;

    localparam int HOST_ENTRIES = 1024;
    localparam int SLOT_W       = $clog2(HOST_ENTRIES);
    localparam int Q_DEPTH      = 2;

    localparam logic [2:0] VERDICT_ACCEPT_NEW    = 3'd0;
    localparam logic [2:0] VERDICT_ACCEPT_RESET  = 3'd1;
    localparam logic [2:0] VERDICT_ACCEPT_UPDATE = 3'd2;
    localparam logic [2:0] VERDICT_REJECT_SIZE   = 3'd3;
    localparam logic [2:0] VERDICT_REJECT_QUOTA  = 3'd4;

    localparam logic [2:0] REG_SIZE_LIMIT    = 3'd0;
    localparam logic [2:0] REG_VOLUME_LIMIT  = 3'd1;
    localparam logic [2:0] REG_MESSAGE_LIMIT = 3'd2;
    localparam logic [2:0] REG_RCPT_LIMIT    = 3'd3;
    localparam logic [2:0] REG_WINDOW_LENGTH = 3'd4;
    localparam logic [2:0] REG_AUTOBL_ENABLE = 3'd5;
    localparam logic [2:0] REG_AUTOBL_THRESH = 3'd6;
    localparam logic [2:0] REG_BL_LIFETIME   = 3'd7;

    localparam logic [31:0] RST_SIZE_LIMIT    = 32'd10240000;
    localparam logic [39:0] RST_VOLUME_LIMIT  = 40'd250000000;
    localparam logic [15:0] RST_MESSAGE_LIMIT = 16'd50;
    localparam logic [15:0] RST_RCPT_LIMIT    = 16'd50;
    localparam logic [31:0] RST_WINDOW_LENGTH = 32'd3600;
    localparam logic        RST_AUTOBL_ENABLE = 1'b0;
    localparam logic [15:0] RST_AUTOBL_THRESH = 16'd3;
    localparam logic [31:0] RST_BL_LIFETIME   = 32'd0;

    typedef struct packed {
        logic [31:0] size_limit;
        logic [39:0] volume_limit;
        logic [15:0] message_limit;
        logic [15:0] recipient_limit;
        logic [31:0] window_length;
        logic        autobl_enable;
        logic [15:0] autobl_threshold;
        logic [31:0] bl_lifetime;
    } cfg_t;

    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        logic [31:0]       size;
        logic [31:0]       now;
        logic              inc;
        logic              oversize;
    } item_t;

    typedef struct packed {
        logic        valid;
        logic [31:0] start;
        logic [15:0] wmsg;
        logic [31:0] tmsg;
        logic [39:0] vol;
        logic [15:0] wrcpt;
        logic [31:0] trcpt;
        logic        aflag;
        logic [15:0] atotal;
    } rec_t;

endpackage

### src/per_host_window_throttle.sv
// ----------------------------------------------------------------------------
// per_host_window_throttle
// Fixed-window per-host rate limiter with abuse marking and blacklist orders.
// ----------------------------------------------------------------------------
// Requests arrive on the in_ channel (valid/stall) as host_slot, message_size,
// now and new_message; one result word per request leaves on the out_ channel
// with verdict, blacklist order and expiry, and the host's window counts.
// Limits are set through the cfg_ write channel (cfg_ready is always high);
// write them only while no request is in flight.
// Each request takes one read-modify-write of its host record in the table:
// a registered read when it is popped in ST_IDLE, then update and result in
// ST_CALC; the sequencer pops no new request until that result is registered.
// A two-word queue sits between the request side and the table sequencer.
// After reset the table is swept clear, one record a cycle, over all 1024
// records; in_stall stays high during that sweep. A stalled result is held
// in the output register; the sequencer waits on it while the queue keeps
// taking requests until it is full.
// ----------------------------------------------------------------------------
module per_host_window_throttle
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [9:0]         host_slot,
    input  logic [31:0]        message_size,
    input  logic [31:0]        now,
    input  logic               new_message,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [2:0]         verdict,
    output logic               blacklist_order,
    output logic [31:0]        blacklist_expiry,
    output logic [15:0]        messages_now,
    output logic [39:0]        volume_now,
    output logic [15:0]        recipients_now,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [39:0]        cfg_data
);

    phwt_pkg::cfg_t   cfg;
    phwt_pkg::item_t  push_item;
    phwt_pkg::item_t  pop_item;
    logic             push;
    logic             pop;
    logic             q_ready;
    logic             q_valid;
    logic             clearing;

    phwt_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg_ready (cfg_ready),
        .cfg       (cfg)
    );

    phwt_front u_front
    (
        .in_valid     (in_valid),
        .host_slot    (host_slot),
        .message_size (message_size),
        .now          (now),
        .new_message  (new_message),
        .size_limit   (cfg.size_limit),
        .clearing     (clearing),
        .q_ready      (q_ready),
        .in_stall     (in_stall),
        .push         (push),
        .item         (push_item)
    );

    phwt_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .q_ready   (q_ready),
        .pop       (pop),
        .q_valid   (q_valid),
        .pop_item  (pop_item)
    );

    phwt_back u_back
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg              (cfg),
        .q_valid          (q_valid),
        .q_item           (pop_item),
        .pop              (pop),
        .clearing         (clearing),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .verdict          (verdict),
        .blacklist_order  (blacklist_order),
        .blacklist_expiry (blacklist_expiry),
        .messages_now     (messages_now),
        .volume_now       (volume_now),
        .recipients_now   (recipients_now)
    );

endmodule

### src/phwt_cfg.sv
// ----------------------------------------------------------------------------
// phwt_cfg
// Configuration register file, written one word at a time.
// ----------------------------------------------------------------------------
module phwt_cfg
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    input  logic [2:0]         cfg_index,
    input  logic [39:0]        cfg_data,
    output logic               cfg_ready,
    output phwt_pkg::cfg_t     cfg
);

    phwt_pkg::cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.size_limit       <= phwt_pkg::RST_SIZE_LIMIT;
            cfg_reg.volume_limit     <= phwt_pkg::RST_VOLUME_LIMIT;
            cfg_reg.message_limit    <= phwt_pkg::RST_MESSAGE_LIMIT;
            cfg_reg.recipient_limit  <= phwt_pkg::RST_RCPT_LIMIT;
            cfg_reg.window_length    <= phwt_pkg::RST_WINDOW_LENGTH;
            cfg_reg.autobl_enable    <= phwt_pkg::RST_AUTOBL_ENABLE;
            cfg_reg.autobl_threshold <= phwt_pkg::RST_AUTOBL_THRESH;
            cfg_reg.bl_lifetime      <= phwt_pkg::RST_BL_LIFETIME;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                phwt_pkg::REG_SIZE_LIMIT:    cfg_reg.size_limit       <= cfg_data[31:0];
                phwt_pkg::REG_VOLUME_LIMIT:  cfg_reg.volume_limit     <= cfg_data;
                phwt_pkg::REG_MESSAGE_LIMIT: cfg_reg.message_limit    <= cfg_data[15:0];
                phwt_pkg::REG_RCPT_LIMIT:    cfg_reg.recipient_limit  <= cfg_data[15:0];
                phwt_pkg::REG_WINDOW_LENGTH: cfg_reg.window_length    <= cfg_data[31:0];
                phwt_pkg::REG_AUTOBL_ENABLE: cfg_reg.autobl_enable    <= cfg_data[0];
                phwt_pkg::REG_AUTOBL_THRESH: cfg_reg.autobl_threshold <= cfg_data[15:0];
                phwt_pkg::REG_BL_LIFETIME:   cfg_reg.bl_lifetime      <= cfg_data[31:0];
                default: ;
            endcase
        end
    end

endmodule

### src/phwt_front.sv
// ----------------------------------------------------------------------------
// phwt_front
// Accepts request words and tags oversize messages before queueing them.
// ----------------------------------------------------------------------------
module phwt_front
(
    input  logic                          in_valid,
    input  logic [9:0]                    host_slot,
    input  logic [31:0]                   message_size,
    input  logic [31:0]                   now,
    input  logic                          new_message,
    input  logic [31:0]                   size_limit,
    input  logic                          clearing,
    input  logic                          q_ready,
    output logic                          in_stall,
    output logic                          push,
    output phwt_pkg::item_t               item
);

    assign in_stall = !q_ready || clearing;
    assign push     = in_valid && !in_stall;

    always_comb
    begin
        item.slot     = host_slot[phwt_pkg::SLOT_W-1:0];
        item.size     = message_size;
        item.now      = now;
        item.inc      = new_message;
        item.oversize = (message_size >= size_limit);
    end

endmodule

### src/phwt_queue.sv
// ----------------------------------------------------------------------------
// phwt_queue
// Short FIFO between the front and the back part.
// ----------------------------------------------------------------------------
`include "per_host_window_throttle_defines.svh"

module phwt_queue
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  phwt_pkg::item_t    push_item,
    output logic               q_ready,
    input  logic               pop,
    output logic               q_valid,
    output phwt_pkg::item_t    pop_item
);

    localparam int PTR_W = $clog2(phwt_pkg::Q_DEPTH);

    phwt_pkg::item_t            fifo_reg [phwt_pkg::Q_DEPTH];
    logic [PTR_W-1:0]           wr_ptr_reg;
    logic [PTR_W-1:0]           rd_ptr_reg;
    logic [PTR_W:0]             count_reg;
    logic [PTR_W:0]             count_next;

    assign q_ready  = (count_reg != (PTR_W+1)'(phwt_pkg::Q_DEPTH));
    assign q_valid  = (count_reg != '0);
    assign pop_item = fifo_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(phwt_pkg::Q_DEPTH - 1)) ? '0
                                                                           : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(phwt_pkg::Q_DEPTH - 1)) ? '0
                                                                           : rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    `PHWT_NEVER(a_no_push_full, push && !q_ready, "queue written while full")
    `PHWT_NEVER(a_no_pop_empty, pop && !q_valid, "queue read while empty")
    `PHWT_ASSERT(a_count_track, (push && !pop) |=> (count_reg == $past(count_reg) + 1'b1), "queue count lost a word")

endmodule

### src/phwt_back.sv
// ----------------------------------------------------------------------------
// phwt_back
// Host record table with a read-modify-write sequencer and result register.
// ----------------------------------------------------------------------------
`include "per_host_window_throttle_defines.svh"

module phwt_back
(
    input  logic               clk,
    input  logic               rst_n,
    input  phwt_pkg::cfg_t     cfg,
    input  logic               q_valid,
    input  phwt_pkg::item_t    q_item,
    output logic               pop,
    output logic               clearing,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [2:0]         verdict,
    output logic               blacklist_order,
    output logic [31:0]        blacklist_expiry,
    output logic [15:0]        messages_now,
    output logic [39:0]        volume_now,
    output logic [15:0]        recipients_now
);

    typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_CALC} state_t;

    state_t                     state_reg;
    logic [phwt_pkg::SLOT_W:0]  clr_cnt_reg;
    phwt_pkg::item_t            cur_reg;
    phwt_pkg::rec_t             mem [phwt_pkg::HOST_ENTRIES];
    phwt_pkg::rec_t             rd_reg;

    logic                       out_valid_reg;
    logic [2:0]                 verdict_reg;
    logic                       order_reg;
    logic [31:0]                expiry_reg;
    logic [15:0]                msgs_reg;
    logic [39:0]                vol_reg;
    logic [15:0]                rcpts_reg;

    phwt_pkg::rec_t             rec_next;
    logic                       rec_write;
    logic [2:0]                 verdict_next;
    logic                       order_next;
    logic [31:0]                expiry_next;
    logic                       out_free;
    logic                       finish;
    logic                       wr_en;
    logic [phwt_pkg::SLOT_W-1:0] wr_addr;
    phwt_pkg::rec_t             wr_data;
    logic                       expired;
    logic                       rcpt_over;
    logic                       over;
    logic                       reject;

    function automatic logic [15:0] sat16(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[16] ? 16'hFFFF : s[15:0];
    endfunction

    function automatic logic [31:0] sat32(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    function automatic logic [39:0] sat40(input logic [39:0] a, input logic [39:0] b);
        logic [40:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[40] ? 40'hFF_FFFF_FFFF : s[39:0];
    endfunction

    assign clearing = (state_reg == ST_CLEAR);
    assign pop      = (state_reg == ST_IDLE) && q_valid;
    assign out_free = !out_valid_reg || !out_stall;
    assign finish   = (state_reg == ST_CALC) && out_free;

    always_comb
    begin
        expired   = ({1'b0, cur_reg.now} > ({1'b0, rd_reg.start} + {1'b0, cfg.window_length}));
        rcpt_over = (rd_reg.wrcpt >= cfg.recipient_limit);
        over      = (rd_reg.wmsg >= cfg.message_limit) || (rd_reg.vol >= cfg.volume_limit)
                    || rcpt_over;
        // A further recipient of a message already counted still passes unless the
        // recipient limit itself is reached.
        reject    = over && !(!cur_reg.inc && !rcpt_over);

        rec_next     = rd_reg;
        rec_write    = 1'b1;
        verdict_next = phwt_pkg::VERDICT_ACCEPT_UPDATE;
        order_next   = 1'b0;
        expiry_next  = '0;

        if (cur_reg.oversize)
        begin
            rec_write    = 1'b0;
            verdict_next = phwt_pkg::VERDICT_REJECT_SIZE;
        end
        else if (!rd_reg.valid)
        begin
            rec_next.valid  = 1'b1;
            rec_next.start  = cur_reg.now;
            rec_next.wmsg   = 16'd1;
            rec_next.tmsg   = 32'd1;
            rec_next.vol    = {8'd0, cur_reg.size};
            rec_next.wrcpt  = 16'd1;
            rec_next.trcpt  = 32'd1;
            rec_next.aflag  = 1'b0;
            rec_next.atotal = '0;
            verdict_next    = phwt_pkg::VERDICT_ACCEPT_NEW;
        end
        else if (expired)
        begin
            rec_next.start  = cur_reg.now;
            rec_next.wmsg   = 16'd1;
            rec_next.vol    = {8'd0, cur_reg.size};
            rec_next.wrcpt  = 16'd1;
            rec_next.tmsg   = sat32(rd_reg.tmsg, {31'd0, cur_reg.inc});
            rec_next.trcpt  = sat32(rd_reg.trcpt, 32'd1);
            rec_next.atotal = sat16(rd_reg.atotal, {15'd0, rd_reg.aflag});
            rec_next.aflag  = 1'b0;
            verdict_next    = phwt_pkg::VERDICT_ACCEPT_RESET;
        end
        else if (reject)
        begin
            rec_next.aflag = 1'b1;
            verdict_next   = phwt_pkg::VERDICT_REJECT_QUOTA;
            if (cfg.autobl_enable
                && (({1'b0, rd_reg.atotal} + 17'd1) >= {1'b0, cfg.autobl_threshold}))
            begin
                order_next = 1'b1;
                if (cfg.bl_lifetime != '0)
                begin
                    expiry_next = sat32(cur_reg.now, cfg.bl_lifetime);
                end
            end
        end
        else
        begin
            rec_next.wrcpt = sat16(rd_reg.wrcpt, 16'd1);
            rec_next.trcpt = sat32(rd_reg.trcpt, 32'd1);
            rec_next.vol   = sat40(rd_reg.vol, {8'd0, cur_reg.size});
            rec_next.wmsg  = sat16(rd_reg.wmsg, {15'd0, cur_reg.inc});
            rec_next.tmsg  = sat32(rd_reg.tmsg, {31'd0, cur_reg.inc});
            rec_next.aflag = 1'b0;
        end
    end

    always_comb
    begin
        if (clearing)
        begin
            wr_en   = 1'b1;
            wr_addr = clr_cnt_reg[phwt_pkg::SLOT_W-1:0];
            wr_data = '0;
        end
        else
        begin
            wr_en   = finish && rec_write;
            wr_addr = cur_reg.slot;
            wr_data = rec_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            rd_reg  <= mem[q_item.slot];
            cur_reg <= q_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
            verdict_reg   <= '0;
            order_reg     <= 1'b0;
            expiry_reg    <= '0;
            msgs_reg      <= '0;
            vol_reg       <= '0;
            rcpts_reg     <= '0;
        end
        else
        begin
            if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_CLEAR:
                begin
                    clr_cnt_reg <= clr_cnt_reg + 1'b1;
                    if (clr_cnt_reg == (phwt_pkg::SLOT_W+1)'(phwt_pkg::HOST_ENTRIES - 1))
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE:
                begin
                    if (q_valid)
                    begin
                        state_reg <= ST_CALC;
                    end
                end
                ST_CALC:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        verdict_reg   <= verdict_next;
                        order_reg     <= order_next;
                        expiry_reg    <= expiry_next;
                        msgs_reg      <= rec_next.valid ? rec_next.wmsg  : '0;
                        vol_reg       <= rec_next.valid ? rec_next.vol   : '0;
                        rcpts_reg     <= rec_next.valid ? rec_next.wrcpt : '0;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign out_valid        = out_valid_reg;
    assign verdict          = verdict_reg;
    assign blacklist_order  = order_reg;
    assign blacklist_expiry = expiry_reg;
    assign messages_now     = msgs_reg;
    assign volume_now       = vol_reg;
    assign recipients_now   = rcpts_reg;

    `PHWT_NEVER(a_no_pop_clear, clearing && pop, "request taken during table clear")
    `PHWT_ASSERT(a_order_reject, (out_valid_reg && order_reg) |-> (verdict_reg == phwt_pkg::VERDICT_REJECT_QUOTA), "blacklist order without quota reject")
    `PHWT_ASSERT(a_expiry_order, (out_valid_reg && (expiry_reg != '0)) |-> order_reg, "expiry given without blacklist order")
    `PHWT_ASSERT(a_hold_result, (out_valid_reg && out_stall) |=> (out_valid_reg && $stable(verdict_reg)), "stalled result lost")

endmodule
